>>> hw/rtl/tssb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssb_pkg: shared types and codes for the three-stack shared buffer
// Word formats of the command and response channels, operation and
// status codes, and the default buffer depth.
// ----------------------------------------------------------------------------
package tssb_pkg;

    // default number of words in the shared store
    localparam int BUFFER_DEPTH_DEF = 16;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // highest valid stack id
    localparam logic [1:0] ID_LAST = 2'd2;

    // command word
    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         stack_id;
        logic signed [31:0] push_value;
    } t_cmd_word;

    // response word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         items_in_stack;
    } t_rsp_word;

endpackage

>>> hw/rtl/tssb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssb_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tssb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/three_stack_shared_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stack_shared_buffer: three stacks in one circular word store
// Push, pop and peek on any of three stacks that share one ram; a push
// that finds no room above its stack first slides the other stacks up.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered with one response word.
// Ready is high only while idle. After the accepting edge a pop or peek
// goes through decode, ram read and reply, a plain push through decode,
// write and reply, and a refused or no-op command through decode and reply.
// A push that finds its stack flush against the next one first rebalances:
// it checks each of the two other stacks in turn and, for each that moves,
// copies its words one per cycle through the ram's read and write ports.
// Ready returns once the response has been handed to the output register,
// which holds it until taken; the reply state waits while that register
// still holds an untaken word.
module three_stack_shared_buffer
    #(
    parameter int BUFFER_DEPTH = tssb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tssb_pkg::t_cmd_word i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tssb_pkg::t_rsp_word o_out_word
);

    import tssb_pkg::*;

    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int CW     = $clog2(BUFFER_DEPTH + 1);
    localparam int SHIFT  = CW + 2;
    localparam int RECIP  = ((1 << SHIFT) + 2) / 3;
    localparam int PW     = 2 * CW + 2;
    localparam logic [AW-1:0] BASE1 = AW'(BUFFER_DEPTH / 3);
    localparam logic [AW-1:0] BASE2 = AW'(2 * BUFFER_DEPTH / 3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PICK,
        S_MOVE,
        S_PUSH,
        S_READ,
        S_REPLY
    } t_state;

    // index arithmetic modulo the depth
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        res = (a == AW'(BUFFER_DEPTH - 1)) ? '0 : a + AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        res = (a == '0) ? AW'(BUFFER_DEPTH - 1) : a - AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] a,
                                            input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(BUFFER_DEPTH)) begin
            s = s - (AW+1)'(BUFFER_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state           r_state;
    logic [1:0]       r_op;
    logic [1:0]       r_id;
    logic [31:0]      r_val;
    logic [AW-1:0]    r_base  [3];
    logic [AW-1:0]    r_top   [3];
    logic [CW-1:0]    r_count [3];
    logic [CW-1:0]    r_free;
    logic [CW-1:0]    r_share;
    logic             r_pass;
    logic [1:0]       r_m;
    logic [AW-1:0]    r_k;
    logic [AW-1:0]    r_src;
    logic [AW-1:0]    r_dst;
    logic [CW-1:0]    r_remain;
    logic             r_wpend;
    logic [AW-1:0]    r_wdst;
    logic [AW-1:0]    r_pos;
    t_rsp_word        r_res;
    logic             r_out_valid;
    t_rsp_word        r_out_word;

    logic [AW-1:0]    w_gap [3];
    logic [PW-1:0]    w_prod;
    logic [1:0]       w_m;
    logic [AW-1:0]    w_gm;
    logic [AW-1:0]    w_k;
    logic [AW-1:0]    w_src0;
    logic             w_id_ok;
    logic [AW-1:0]    w_top_dec;
    logic [CW+4:0]    w_cnt_x;
    logic [CW+4:0]    w_cnt_inc_x;
    logic [CW+4:0]    w_cnt_dec_x;
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [31:0]      w_ram_wdata;
    logic             w_ram_re;
    logic [AW-1:0]    w_ram_raddr;
    logic [31:0]      w_ram_rdata;

    // free space above each stack, up to the next stack's base
    for (genvar gi = 0; gi < 3; gi++) begin : g_gap
        logic [AW:0] w_wrap;
        assign w_wrap = (AW+1)'(BUFFER_DEPTH) + {1'b0, r_base[(gi + 1) % 3]}
                        - {1'b0, r_top[gi]};
        assign w_gap[gi] = (r_base[(gi + 1) % 3] >= r_top[gi])
                         ? r_base[(gi + 1) % 3] - r_top[gi]
                         : w_wrap[AW-1:0];
    end

    // free / 3 by reciprocal multiply, exact for all free counts
    assign w_prod = PW'(r_free) * PW'(RECIP);

    // stack visited in this rebalance pass: id+2 first, then id+1
    always_comb begin
        case (r_id)
            2'd0:    w_m = r_pass ? 2'd1 : 2'd2;
            2'd1:    w_m = r_pass ? 2'd2 : 2'd0;
            default: w_m = r_pass ? 2'd0 : 2'd1;
        endcase
    end

    assign w_gm   = w_gap[w_m];
    assign w_k    = w_gm - AW'(r_share);
    assign w_src0 = f_dec(r_top[w_m]);

    // addressed stack
    assign w_id_ok   = (r_id <= ID_LAST);
    assign w_top_dec = f_dec(r_top[r_id]);
    assign w_cnt_x     = (CW+5)'(r_count[r_id]);
    assign w_cnt_inc_x = (CW+5)'(r_count[r_id]) + (CW+5)'(1);
    assign w_cnt_dec_x = (CW+5)'(r_count[r_id]) - (CW+5)'(1);

    // ram write: copy word during a move, new word during a push
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_wdst;
        w_ram_wdata = w_ram_rdata;
        if (r_state == S_MOVE && r_wpend) begin
            w_ram_we = 1'b1;
        end else if (r_state == S_PUSH) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_top[r_id];
            w_ram_wdata = r_val;
        end
    end

    // ram read: top word for pop/peek, source word during a move
    always_comb begin
        w_ram_re    = 1'b0;
        w_ram_raddr = r_src;
        if (r_state == S_EXEC) begin
            w_ram_re    = w_id_ok && (r_op == OP_POP || r_op == OP_PEEK)
                          && (r_count[r_id] != '0);
            w_ram_raddr = w_top_dec;
        end else if (r_state == S_MOVE) begin
            w_ram_re = (r_remain != '0);
        end
    end

    tssb_ram #(
        .WIDTH (32),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // sequencer, stack pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base[0]   <= '0;
            r_base[1]   <= BASE1;
            r_base[2]   <= BASE2;
            r_top[0]    <= '0;
            r_top[1]    <= BASE1;
            r_top[2]    <= BASE2;
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_count[2]  <= '0;
            r_free      <= CW'(BUFFER_DEPTH);
            r_pass      <= 1'b0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output word loaded by the reply, cleared when taken downstream
            if (r_state == S_REPLY && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_word.operation;
                        r_id    <= i_in_word.stack_id;
                        r_val   <= i_in_word.push_value;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_res.read_value <= '0;
                    if (!w_id_ok) begin
                        r_res.status         <= ST_OK;
                        r_res.items_in_stack <= '0;
                        r_state              <= S_REPLY;
                    end else begin
                        r_res.items_in_stack <= w_cnt_x[4:0];
                        case (r_op) inside
                            OP_PUSH: begin
                                if (r_free == '0) begin
                                    r_res.status <= ST_FULL;
                                    r_state      <= S_REPLY;
                                end else if (w_gap[r_id] == '0) begin
                                    r_res.status <= ST_OK;
                                    r_share      <= w_prod[SHIFT +: CW];
                                    r_pass       <= 1'b0;
                                    r_state      <= S_PICK;
                                end else begin
                                    r_res.status <= ST_OK;
                                    r_state      <= S_PUSH;
                                end
                            end
                            OP_POP, OP_PEEK: begin
                                if (r_count[r_id] == '0) begin
                                    r_res.status <= ST_EMPTY;
                                    r_state      <= S_REPLY;
                                end else begin
                                    r_res.status <= ST_OK;
                                    r_pos        <= w_top_dec;
                                    r_state      <= S_READ;
                                end
                            end
                            default: begin
                                r_res.status <= ST_OK;
                                r_state      <= S_REPLY;
                            end
                        endcase
                    end
                end

                // decide whether the visited stack moves up
                S_PICK: begin
                    if (CW'(w_gm) > r_share) begin
                        r_m      <= w_m;
                        r_k      <= w_k;
                        r_src    <= w_src0;
                        r_dst    <= f_add(w_src0, w_k);
                        r_remain <= r_count[w_m];
                        r_wpend  <= 1'b0;
                        r_state  <= S_MOVE;
                    end else if (!r_pass) begin
                        r_pass <= 1'b1;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end

                // copy top word first, one word per cycle
                S_MOVE: begin
                    if (r_remain != '0) begin
                        r_src    <= f_dec(r_src);
                        r_dst    <= f_dec(r_dst);
                        r_remain <= r_remain - CW'(1);
                        r_wdst   <= r_dst;
                        r_wpend  <= 1'b1;
                    end else begin
                        r_wpend     <= 1'b0;
                        r_base[r_m] <= f_add(r_base[r_m], r_k);
                        r_top[r_m]  <= f_add(r_top[r_m], r_k);
                        if (!r_pass) begin
                            r_pass  <= 1'b1;
                            r_state <= S_PICK;
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end

                S_PUSH: begin
                    r_top[r_id]          <= f_inc(r_top[r_id]);
                    r_count[r_id]        <= r_count[r_id] + CW'(1);
                    r_free               <= r_free - CW'(1);
                    r_res.read_value     <= '0;
                    r_res.status         <= ST_OK;
                    r_res.items_in_stack <= w_cnt_inc_x[4:0];
                    r_state              <= S_REPLY;
                end

                S_READ: begin
                    r_res.read_value <= w_ram_rdata;
                    r_res.status     <= ST_OK;
                    if (r_op == OP_POP) begin
                        r_top[r_id]          <= r_pos;
                        r_count[r_id]        <= r_count[r_id] - CW'(1);
                        r_free               <= r_free + CW'(1);
                        r_res.items_in_stack <= w_cnt_dec_x[4:0];
                    end else begin
                        r_res.items_in_stack <= w_cnt_x[4:0];
                    end
                    r_state <= S_REPLY;
                end

                S_REPLY: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_word <= r_res;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // stack counts and free space always account for the whole store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CW+2)'(r_count[0]) + (CW+2)'(r_count[1]) + (CW+2)'(r_count[2])
         + (CW+2)'(r_free)) == (CW+2)'(BUFFER_DEPTH))
        else $error("stack counts and free space disagree");

    // a push always consumes one free word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_free == $past(r_free) - CW'(1)))
        else $error("push did not consume a free word");

    // rebalancing only starts with free space available
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK || r_state == S_MOVE) |-> (r_free != '0))
        else $error("rebalance with a full store");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for three_stack_shared_buffer
// Drives push, pop, peek and unused command words through the command channel with random
// gaps and output stalls. A shadow copy of the three stacks, or a typed table row, predicts
// every response word, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import tssb_pkg::*;

    localparam int DEPTH        = BUFFER_DEPTH_DEF;
    localparam int IW           = $clog2(DEPTH);
    localparam int N_RANDOM     = 720;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_NS     = 10_000_000;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ID_NONE   = 2'd3;

    // one line of the directed table
    typedef struct {
        t_cmd_word cmd;
        int        reps;
        bit        chk;
        t_rsp_word rsp;
    } t_dir_row;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_cmd_word in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_rsp_word out_word;

    // shadow copy of the stacks
    logic [31:0]   word_copy [DEPTH];
    logic [IW-1:0] base_of [3];
    logic [IW-1:0] top_of [3];
    logic [IW:0]   count_of [3];
    logic [IW:0]   room_above [3];
    logic [IW:0]   free_words;

    t_rsp_word pending_rsp [$];
    t_dir_row  dir_rows [$];

    int n_errors  = 0;
    int n_words   = 0;
    int n_checked = 0;
    int n_push    = 0;
    int n_full    = 0;
    int n_read    = 0;
    int n_empty   = 0;
    int n_slides  = 0;
    int n_wraps   = 0;
    int rx_hold   = 0;
    int held      = 0;

    three_stack_shared_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [IW-1:0] wrap(int unsigned v);
        return IW'(v % DEPTH);
    endfunction

    // distance from each top to the base of the next stack
    function automatic void measure_rooms();
        int unsigned cur, nxt;
        for (int s = 0; s < 3; s++) begin
            cur = 32'(top_of[s]);
            nxt = 32'(base_of[(s + 1) % 3]);
            room_above[s] = (nxt > cur) ? (IW+1)'(nxt - cur)
                                        : (IW+1)'(wrap(nxt + DEPTH - cur));
        end
    endfunction

    function automatic void clear_stacks();
        for (int i = 0; i < DEPTH; i++) word_copy[i] = '0;
        for (int s = 0; s < 3; s++) begin
            base_of[s]  = wrap(s * DEPTH / 3);
            top_of[s]   = base_of[s];
            count_of[s] = '0;
        end
        measure_rooms();
        free_words = (IW+1)'(DEPTH);
    endfunction

    // shift one stack up by k words, top word first
    function automatic void slide_up(int unsigned s, int unsigned k);
        for (int i = int'(count_of[s]) - 1; i >= 0; i--)
            word_copy[wrap(base_of[s] + i + k)] = word_copy[wrap(base_of[s] + i)];
        base_of[s] = wrap(base_of[s] + k);
        top_of[s]  = wrap(top_of[s] + k);
        measure_rooms();
        n_slides++;
    endfunction

    // make room above stack id by moving the other two up where they hold more than their share
    function automatic void rebalance(int unsigned id);
        int unsigned share, m;
        share = 32'(free_words) / 3;
        m = (id + 1) % 3;
        repeat (3) begin
            m = (m + 1) % 3;
            if (m != id && room_above[m] > share) slide_up(m, room_above[m] - share);
        end
    endfunction

    // apply one command word to the shadow stacks, return its response word
    function automatic t_rsp_word stack_apply(t_cmd_word c);
        t_rsp_word     r;
        int unsigned   id;
        logic [IW-1:0] pos;
        r  = '0;
        id = 32'(c.stack_id);
        if (c.stack_id <= ID_LAST) begin
            if (c.operation == OP_PUSH) begin
                n_push++;
                if (free_words == 0) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    if (room_above[id] == 0) rebalance(id);
                    word_copy[top_of[id]] = c.push_value;
                    top_of[id] = wrap(top_of[id] + 1);
                    free_words--;
                    measure_rooms();
                    count_of[id]++;
                end
            end else if (c.operation == OP_POP || c.operation == OP_PEEK) begin
                n_read++;
                if (count_of[id] == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    pos = wrap(top_of[id] + DEPTH - 1);
                    r.read_value = word_copy[pos];
                    if (c.operation == OP_POP) begin
                        if (pos > top_of[id]) n_wraps++;
                        top_of[id] = pos;
                        count_of[id]--;
                        measure_rooms();
                        free_words++;
                    end
                end
            end
            r.items_in_stack = count_of[id];
        end
        return r;
    endfunction

    // compare an arriving response word with the oldest expectation
    function automatic void check_response(t_rsp_word got);
        t_rsp_word want;
        if (pending_rsp.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("%0t: response word %h with none expected", $time, got);
            return;
        end
        want = pending_rsp.pop_front();
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.items_in_stack !== want.items_in_stack) begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: response %0d expected value %h status %0d count %0d, got %h %0d %0d",
                         $time, n_checked, want.read_value, want.status, want.items_in_stack,
                         got.read_value, got.status, got.items_in_stack);
        end
        n_checked++;
    endfunction

    // table rows: typed expectation, or random push values checked by the shadow copy
    function automatic t_dir_row typed(logic [1:0] op, logic [1:0] id, logic [31:0] val,
                                       logic [31:0] rd, logic [1:0] st, logic [4:0] cnt);
        t_dir_row r;
        r.cmd  = '{operation: op, stack_id: id, push_value: val};
        r.reps = 1;
        r.chk  = 1'b1;
        r.rsp  = '{read_value: rd, status: st, items_in_stack: cnt};
        return r;
    endfunction

    function automatic t_dir_row plain(logic [1:0] op, logic [1:0] id, int reps);
        t_dir_row r;
        r.cmd  = '{operation: op, stack_id: id, push_value: '0};
        r.reps = reps;
        r.chk  = 1'b0;
        r.rsp  = '0;
        return r;
    endfunction

    // random command word; mode leans toward filling, draining or a mix
    function automatic t_cmd_word random_cmd(int mode, logic [1:0] focus);
        t_cmd_word   c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 11))
            0:       c.push_value = 32'h7fff_ffff;
            1:       c.push_value = 32'h8000_0000;
            2:       c.push_value = 32'hffff_ffff;
            default: c.push_value = $urandom;
        endcase
        c.stack_id = ($urandom_range(0, 2) == 0) ? focus : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 3) c.stack_id = ID_NONE;
        if (roll < 3)
            c.operation = OP_UNUSED;
        else if (roll < (mode == 0 ? 75 : mode == 1 ? 30 : 52))
            c.operation = OP_PUSH;
        else if (roll < (mode == 0 ? 88 : mode == 1 ? 82 : 80))
            c.operation = OP_POP;
        else
            c.operation = OP_PEEK;
        return c;
    endfunction

    // present one word after a gap and record its expectation once taken
    task automatic offer_word(t_cmd_word c, int gap, bit has_typed, t_rsp_word typed_rsp);
        t_rsp_word want;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= c;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        want = stack_apply(c);
        pending_rsp.push_back(has_typed ? typed_rsp : want);
        n_words++;
    endtask

    // response side: random stalls, bursts of steady ready, one long hold-off
    initial begin : receiver
        int stall;
        bit burst;
        burst = 1'b0;
        for (int taken = 0; ; taken++) begin
            if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            stall = burst ? 0 : $urandom_range(0, 14);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                held   += rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            check_response(out_word);
        end
    end

    // command side and end of run
    initial begin : sender
        t_cmd_word  c;
        int         mode;
        logic [1:0] focus;
        bit         burst;
        mode  = 2;
        focus = 2'd0;
        burst = 1'b0;

        // directed table
        dir_rows.push_back(typed(OP_PEEK,   2'd0,    32'h0,         32'h0, ST_EMPTY, 5'd0));
        dir_rows.push_back(typed(OP_POP,    2'd2,    32'h0,         32'h0, ST_EMPTY, 5'd0));
        dir_rows.push_back(typed(OP_PUSH,   2'd0,    32'h7fff_ffff, 32'h0, ST_OK,    5'd1));
        dir_rows.push_back(typed(OP_PUSH,   2'd0,    32'h8000_0000, 32'h0, ST_OK,    5'd2));
        dir_rows.push_back(typed(OP_PEEK,   2'd0,    32'h0, 32'h8000_0000, ST_OK,    5'd2));
        dir_rows.push_back(typed(OP_POP,    2'd0,    32'h0, 32'h8000_0000, ST_OK,    5'd1));
        dir_rows.push_back(typed(OP_UNUSED, 2'd0,    32'hffff_ffff, 32'h0, ST_OK,    5'd1));
        dir_rows.push_back(typed(OP_PUSH,   ID_NONE, 32'hffff_ffff, 32'h0, ST_OK,    5'd0));
        dir_rows.push_back(typed(OP_POP,    ID_NONE, 32'h0,         32'h0, ST_OK,    5'd0));
        dir_rows.push_back(typed(OP_PUSH,   2'd1,    32'hffff_ffff, 32'h0, ST_OK,    5'd1));
        dir_rows.push_back(typed(OP_POP,    2'd1,    32'h0, 32'hffff_ffff, ST_OK,    5'd0));
        // stack 0 runs into stack 1 and forces a rebalance, then stack 2 fills the rest
        dir_rows.push_back(plain(OP_PUSH, 2'd0, 6));
        dir_rows.push_back(plain(OP_PUSH, 2'd2, 9));
        dir_rows.push_back(typed(OP_PUSH,   2'd1,    32'h5555_aaaa, 32'h0, ST_FULL,  5'd0));
        dir_rows.push_back(typed(OP_PUSH,   2'd0,    32'h0,         32'h0, ST_FULL,  5'd7));
        dir_rows.push_back(plain(OP_PEEK, 2'd2, 1));
        dir_rows.push_back(plain(OP_POP,  2'd2, 4));

        // reset
        clear_stacks();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[k]) begin
            for (int r = 0; r < dir_rows[k].reps; r++) begin
                c = dir_rows[k].cmd;
                if (!dir_rows[k].chk) c.push_value = $urandom;
                offer_word(c, $urandom_range(0, 14), dir_rows[k].chk, dir_rows[k].rsp);
            end
        end

        // random part
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) begin
                mode  = $urandom_range(0, 2);
                focus = 2'($urandom_range(0, 2));
            end
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            // long output hold-off while words keep coming
            if (n == 200) rx_hold = HOLD_CYCLES;
            // let everything drain before going on
            if (n == 450) begin
                in_valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            offer_word(random_cmd(mode, focus), burst ? 0 : $urandom_range(0, 14), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // wait for the last responses and watch for strays
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d command words: %0d pushes (%0d refused full), %0d pops/peeks (%0d empty)",
                 n_words, n_push, n_full, n_read, n_empty);
        $display("%0d stack slides, %0d pop wraps, %0d hold-off cycles, %0d responses, %0d errors",
                 n_slides, n_wraps, held, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("** three_stack_shared_buffer: PASSED **");
        end else begin
            $display("** three_stack_shared_buffer: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d responses outstanding", pending_rsp.size());
        $display("** three_stack_shared_buffer: FAILED **");
        $finish;
    end

endmodule
